>>> rtl/core/rma_pkg.sv
`timescale 1ns / 1ps

package rma_pkg;

  localparam int DEPTH      = 16;
  localparam int SAMPLE_W   = 16;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int FILL_W     = $clog2(DEPTH + 1);
  localparam int SUM_W      = SAMPLE_W + $clog2(DEPTH);
  localparam int STEP_W     = $clog2(SUM_W);
  localparam int WIN_LEN_W  = 5;
  localparam int THRESH_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_THRESHOLD = CFG_IDX_W'(1);

  localparam logic [WIN_LEN_W-1:0] WINDOW_LENGTH_RESET  = WIN_LEN_W'(16);
  localparam logic [THRESH_W-1:0]  JUMP_THRESHOLD_RESET = THRESH_W'(51);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_UPDATE,
    ST_DIV_INIT,
    ST_DIV,
    ST_LOAD
  } state_t;

endpackage

>>> rtl/core/rma_if.sv
`timescale 1ns / 1ps

interface rma_sample_if;
  import rma_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface rma_result_if;
  import rma_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] mean;
  logic [FILL_W-1:0]          fill_count;
  logic                       restarted;
  modport source (output valid, output mean, output fill_count, output restarted,
                  input ready);
  modport sink (input valid, input mean, input fill_count, input restarted,
                output ready);
endinterface

interface rma_cfg_if;
  import rma_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_W-1:0]    index;
  logic [CFG_DATA_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/resetting_moving_average_unit.sv
`timescale 1ns / 1ps
// Channel   Role  Payload
// samples   sink  sample (signed Q8.8)
// results   src   mean (signed Q8.8), fill_count, restarted
// cfg       sink  index, data (window_length, jump_threshold)
//
// Each sample passes from its transfer to a valid result through the jump test, the window
// update, the divider setup, the bit-serial restoring divider that forms the mean and the
// result load, in that order. A new sample is taken only in the idle state, so the block is
// through with one sample before it takes the next.
// The result register lets a new sample be taken while the last result waits;
// the block stalls before loading only if that result is still untaken.
// Reset is synchronous; the sample ring holds no reset and no unwritten entry is ever used.

module resetting_moving_average_unit (
  input  logic             clk,
  input  logic             rst,
  rma_sample_if.sink       samples,
  rma_result_if.source     results,
  rma_cfg_if.sink          cfg
);
  import rma_pkg::*;

  state_t state, state_next;

  logic signed [SAMPLE_W-1:0] ring [DEPTH];
  logic signed [SAMPLE_W-1:0] ring_rd;
  logic signed [SAMPLE_W-1:0] cur;
  logic signed [SAMPLE_W-1:0] previous_sample;
  logic signed [SUM_W-1:0]    window_sum;
  logic [FILL_W-1:0]          fill_level;
  logic [IDX_W-1:0]           oldest_slot;
  logic [WIN_LEN_W-1:0]       window_length;
  logic [THRESH_W-1:0]        jump_threshold;
  logic                       restart;

  logic [SUM_W-1:0]  quo;
  logic [FILL_W-1:0] rem;
  logic [STEP_W-1:0] step;
  logic              neg;

  logic [FILL_W-1:0]          len;
  logic signed [SAMPLE_W:0]   diff;
  logic [SAMPLE_W:0]          mag;
  logic                       jump;
  logic [FILL_W-1:0]          fill_eff;
  logic signed [SUM_W-1:0]    sum_eff;
  logic [IDX_W-1:0]           oldest_eff;
  logic signed [SUM_W-1:0]    cur_ext;
  logic signed [SUM_W-1:0]    old_ext;
  logic                       not_full;
  logic [IDX_W-1:0]           wr_addr;
  logic                       wr_en;
  logic [FILL_W:0]            trial;
  logic                       trial_ge;
  logic                       out_free;

  assign samples.ready = (state == ST_IDLE) && !cfg.valid;
  assign cfg.ready     = (state == ST_IDLE);
  assign out_free      = !results.valid || results.ready;

  always_comb begin
    if (window_length == '0) begin
      len = FILL_W'(1);
    end else if (int'(window_length) > DEPTH) begin
      len = FILL_W'(DEPTH);
    end else begin
      len = FILL_W'(window_length);
    end
  end

  assign diff = {cur[SAMPLE_W-1], cur} - {previous_sample[SAMPLE_W-1], previous_sample};
  assign mag  = diff[SAMPLE_W] ? (SAMPLE_W + 1)'(-diff) : (SAMPLE_W + 1)'(diff);
  assign jump = (fill_level != '0) && (mag > {1'b0, jump_threshold});

  assign fill_eff   = restart ? '0 : fill_level;
  assign sum_eff    = restart ? '0 : window_sum;
  assign oldest_eff = restart ? '0 : oldest_slot;
  assign cur_ext    = SUM_W'(cur);
  assign old_ext    = SUM_W'(ring_rd);
  assign not_full   = fill_eff < len;
  assign wr_addr    = not_full ? fill_eff[IDX_W-1:0] : oldest_eff;
  assign wr_en      = (state == ST_UPDATE);

  assign trial    = {rem, quo[SUM_W-1]};
  assign trial_ge = trial >= {1'b0, fill_level};

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (samples.valid && samples.ready) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK:    state_next = ST_UPDATE;
      ST_UPDATE:   state_next = ST_DIV_INIT;
      ST_DIV_INIT: state_next = ST_DIV;
      ST_DIV: begin
        if (step == STEP_W'(SUM_W - 1)) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[wr_addr] <= cur;
    end
    ring_rd <= ring[oldest_slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_sum      <= '0;
      fill_level      <= '0;
      oldest_slot     <= '0;
      previous_sample <= '0;
      window_length   <= WINDOW_LENGTH_RESET;
      jump_threshold  <= JUMP_THRESHOLD_RESET;
      results.valid   <= 1'b0;
    end else begin
      if (state == ST_LOAD && out_free) begin
        results.valid <= 1'b1;
      end else if (results.valid && results.ready) begin
        results.valid <= 1'b0;
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_WINDOW_LENGTH: begin
            window_length <= cfg.data[WIN_LEN_W-1:0];
            window_sum    <= '0;
            fill_level    <= '0;
            oldest_slot   <= '0;
          end
          REG_JUMP_THRESHOLD: begin
            jump_threshold <= cfg.data[THRESH_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (state == ST_UPDATE) begin
        previous_sample <= cur;
        if (not_full) begin
          window_sum  <= sum_eff + cur_ext;
          fill_level  <= fill_eff + 1'b1;
          oldest_slot <= oldest_eff;
        end else begin
          window_sum <= window_sum - old_ext + cur_ext;
          if (FILL_W'(oldest_slot) + 1'b1 == len) begin
            oldest_slot <= '0;
          end else begin
            oldest_slot <= oldest_slot + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (samples.valid && samples.ready) begin
          cur <= samples.sample;
        end
      end
      ST_CHECK: begin
        restart <= jump;
      end
      ST_DIV_INIT: begin
        neg  <= window_sum[SUM_W-1];
        quo  <= window_sum[SUM_W-1] ? SUM_W'(-window_sum) : SUM_W'(window_sum);
        rem  <= '0;
        step <= '0;
      end
      ST_DIV: begin
        if (trial_ge) begin
          rem <= FILL_W'(trial - {1'b0, fill_level});
        end else begin
          rem <= trial[FILL_W-1:0];
        end
        quo  <= {quo[SUM_W-2:0], trial_ge};
        step <= step + 1'b1;
      end
      ST_LOAD: begin
        if (out_free) begin
          results.mean       <= neg ? -quo[SAMPLE_W-1:0] : quo[SAMPLE_W-1:0];
          results.fill_count <= fill_level;
          results.restarted  <= restart;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> test/rma_average_checker.sv
`timescale 1ns / 1ps

module rma_average_checker
  import rma_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  rma_sample_if       smp,
  rma_result_if       res,
  rma_cfg_if          cfg,
  output int unsigned failures,
  output int unsigned pending,
  output int unsigned means_checked,
  output int unsigned restarts_seen
);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mean;
    logic [FILL_W-1:0]          fill_count;
    logic                       restarted;
  } average_t;

  logic signed [SAMPLE_W-1:0] held [DEPTH];
  int                         running_total;
  int                         held_count;
  int                         replace_slot;
  logic signed [SAMPLE_W-1:0] last_sample;
  logic [WIN_LEN_W-1:0]       span_cfg;
  logic [THRESH_W-1:0]        step_limit_cfg;
  average_t                   awaited_q [$];
  int unsigned                fail_total;
  int unsigned                checked_total;
  int unsigned                restart_total;

  function automatic void clear_window();
    running_total = 0;
    held_count    = 0;
    replace_slot  = 0;
  endfunction

  function automatic average_t next_average(input logic signed [SAMPLE_W-1:0] s);
    int       span;
    int       step;
    int       slot;
    average_t r;
    span = (span_cfg == '0) ? 1 : ((int'(span_cfg) > DEPTH) ? DEPTH : int'(span_cfg));
    r.restarted = 1'b0;
    if (held_count != 0) begin
      step = int'(s) - int'(last_sample);
      if (step < 0) step = -step;
      if (step > int'(step_limit_cfg)) begin
        clear_window();
        r.restarted = 1'b1;
      end
    end
    if (held_count < span) begin
      held[held_count] = s;
      running_total += int'(s);
      held_count++;
    end else begin
      slot = replace_slot % span;
      running_total -= int'(held[slot]);
      held[slot] = s;
      running_total += int'(s);
      replace_slot = (slot + 1) % span;
    end
    last_sample  = s;
    r.mean       = SAMPLE_W'(running_total / held_count);
    r.fill_count = FILL_W'(held_count);
    return r;
  endfunction

  task automatic log_mismatch(input string what, input average_t want, input average_t got);
    fail_total++;
    if (fail_total <= 10) begin
      $display("%0t: %s: expected mean %0d fill %0d restarted %0b, got mean %0d fill %0d restarted %0b",
               $time, what, $signed(want.mean), want.fill_count, want.restarted,
               $signed(got.mean), got.fill_count, got.restarted);
    end
  endtask

  always @(posedge clk) begin
    average_t got;
    average_t want;
    if (rst) begin
      clear_window();
      last_sample    = '0;
      span_cfg       = WINDOW_LENGTH_RESET;
      step_limit_cfg = JUMP_THRESHOLD_RESET;
      awaited_q.delete();
      fail_total    = 0;
      checked_total = 0;
      restart_total = 0;
    end else begin
      if (res.valid && res.ready) begin
        got.mean       = res.mean;
        got.fill_count = res.fill_count;
        got.restarted  = res.restarted;
        checked_total++;
        if (got.restarted) restart_total++;
        if (awaited_q.size() == 0) begin
          log_mismatch("result transfer with nothing outstanding", '0, got);
        end else begin
          want = awaited_q.pop_front();
          if (got.mean !== want.mean || got.fill_count !== want.fill_count ||
              got.restarted !== want.restarted) begin
            log_mismatch("result mismatch", want, got);
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_WINDOW_LENGTH) begin
          span_cfg = cfg.data[WIN_LEN_W-1:0];
          clear_window();
        end else if (cfg.index == REG_JUMP_THRESHOLD) begin
          step_limit_cfg = cfg.data[THRESH_W-1:0];
        end
      end
      if (smp.valid && smp.ready) begin
        awaited_q.insert(awaited_q.size(), next_average(smp.sample));
      end
    end
    failures      <= fail_total;
    pending       <= awaited_q.size();
    means_checked <= checked_total;
    restarts_seen <= restart_total;
  end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rma_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int SETTLE_WAIT  = 40;
  localparam int PHASES       = 14;
  localparam int PHASE_ITEMS  = 132;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LOW  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HIGH = CFG_IDX_W'(3);

  logic        clk = 1'b0;
  logic        rst;
  bit          calm;
  int unsigned samples_sent;
  int unsigned reg_writes;
  int unsigned quiet_cycles;
  int unsigned failures;
  int unsigned pending;
  int unsigned means_checked;
  int unsigned restarts_seen;

  rma_sample_if smp ();
  rma_result_if res ();
  rma_cfg_if    cfg ();

  resetting_moving_average_unit dut (
    .clk     (clk),
    .rst     (rst),
    .samples (smp),
    .results (res),
    .cfg     (cfg)
  );

  rma_average_checker mean_check (
    .clk           (clk),
    .rst           (rst),
    .smp           (smp),
    .res           (res),
    .cfg           (cfg),
    .failures      (failures),
    .pending       (pending),
    .means_checked (means_checked),
    .restarts_seen (restarts_seen)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    int unsigned pick;
    int unsigned hold_left;
    hold_left = 0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        res.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else begin
        pick = $urandom_range(0, 999);
        if (calm || pick >= 84) begin
          res.ready <= 1'b1;
        end else begin
          res.ready <= 1'b0;
          if (pick >= 80) hold_left = $urandom_range(9, 29);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (smp.valid && smp.ready) || (res.valid && res.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int clamp_q88(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  task automatic send_sample(input int value);
    int unsigned pick;
    pick = $urandom_range(0, 999);
    if (!calm && pick < 84) begin
      smp.valid <= 1'b0;
      repeat ((pick < 80) ? 1 : $urandom_range(10, 30)) @(posedge clk);
    end
    smp.valid  <= 1'b1;
    smp.sample <= SAMPLE_W'(value);
    @(posedge clk);
    while (!smp.ready) @(posedge clk);
    samples_sent++;
  endtask

  task automatic settle();
    smp.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  task automatic random_phase(input int unsigned count, input logic [WIN_LEN_W-1:0] span);
    logic [CFG_DATA_W-1:0] span_word;
    int                    limit;
    int                    level;
    int                    next;
    int                    cap;
    int                    sign;
    int unsigned           pick;
    settle();
    span_word = CFG_DATA_W'($urandom);
    span_word[WIN_LEN_W-1:0] = span;
    case ($urandom_range(0, 7))
      0:       limit = 0;
      1:       limit = 65535;
      2, 3:    limit = $urandom_range(0, 64);
      4, 5:    limit = $urandom_range(0, 2000);
      6:       limit = int'(JUMP_THRESHOLD_RESET);
      default: limit = $urandom_range(0, 65535);
    endcase
    if ($urandom_range(0, 1) == 1) begin
      write_reg(REG_WINDOW_LENGTH, int'(span_word));
      write_reg(REG_JUMP_THRESHOLD, limit);
    end else begin
      write_reg(REG_JUMP_THRESHOLD, limit);
      write_reg(REG_WINDOW_LENGTH, int'(span_word));
    end
    cap   = (limit < 4096) ? limit : 4096;
    level = int'($urandom_range(0, 65535)) - 32768;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      sign = ($urandom_range(0, 1) == 1) ? 1 : -1;
      if (pick < 10) begin
        next = clamp_q88(level + sign * (limit + int'($urandom_range(0, 1))));
      end else if (pick < 85) begin
        next = clamp_q88(level + int'($urandom_range(0, 2 * cap)) - cap);
      end else if (pick < 95) begin
        next = clamp_q88(level + sign * (limit + 1 + int'($urandom_range(0, 8000))));
      end else begin
        next = int'($urandom_range(0, 65535)) - 32768;
      end
      send_sample(next);
      level = next;
    end
  endtask

  initial begin
    int unsigned          ph;
    logic [WIN_LEN_W-1:0] span;
    calm         = 1'b0;
    samples_sent = 0;
    reg_writes   = 0;
    rst        <= 1'b1;
    smp.valid  <= 1'b0;
    smp.sample <= '0;
    cfg.valid  <= 1'b0;
    cfg.index  <= '0;
    cfg.data   <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: the first sample meets an empty window, then a step of exactly
    // the threshold and one just above it.
    send_sample(32767);
    send_sample(32767);
    send_sample(32716);
    send_sample(32664);
    settle();
    write_reg(REG_JUMP_THRESHOLD, 65535);
    write_reg(REG_SPARE_LOW, 0);
    write_reg(REG_SPARE_HIGH, 65535);
    send_sample(-32768);
    send_sample(32767);
    send_sample(-32768);
    send_sample(-1);
    send_sample(1);
    settle();
    write_reg(REG_JUMP_THRESHOLD, 0);
    send_sample(1);
    send_sample(2);
    send_sample(2);
    settle();
    write_reg(REG_JUMP_THRESHOLD, 65535);
    write_reg(REG_WINDOW_LENGTH, 16'hFFE0);
    send_sample(-32768);
    send_sample(32767);
    settle();
    write_reg(REG_WINDOW_LENGTH, 2);
    send_sample(100);
    send_sample(-300);
    send_sample(7);
    send_sample(-7);

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       span = 5'd31;
        1:       span = 5'd0;
        2:       span = 5'd1;
        3:       span = 5'd16;
        default: span = ($urandom_range(0, 3) == 0) ? WIN_LEN_W'($urandom_range(17, 31))
                                                    : WIN_LEN_W'($urandom_range(1, 16));
      endcase
      calm = (ph == 6);
      random_phase(PHASE_ITEMS, span);
    end
    calm = 1'b0;
    settle();

    $display("run summary: %0d samples sent and %0d means checked, %0d of them restarts,",
             samples_sent, means_checked, restarts_seen);
    $display("run summary: %0d register writes across window lengths 0 to 31 and thresholds",
             reg_writes);
    if (failures == 0 && pending == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

>>> resetting_moving_average_unit.f
rtl/core/rma_pkg.sv
rtl/core/rma_if.sv
rtl/core/resetting_moving_average_unit.sv
test/rma_average_checker.sv
test/testbench.sv
